// ===== design/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the i2c master byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned PLEN_W   = 16;
    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned BYTE_W   = 8;

    localparam logic [PLEN_W-1:0] PHASE_LEN_RESET = 16'd150;
    localparam logic              REG_PHASE_LEN   = 1'b0;
    localparam logic [3:0]        LAST_BIT_SLOT   = 4'd8;
    localparam logic [1:0]        LAST_PHASE      = 2'd3;

    typedef enum logic [FUNC_W-1:0] {
        CMD_IDLE      = 3'd0,
        CMD_START     = 3'd1,
        CMD_STOP      = 3'd2,
        CMD_WRITE     = 3'd3,
        CMD_READ_ACK  = 3'd4,
        CMD_READ_NACK = 3'd5
    } cmd_t;

    typedef struct packed {
        logic              scl_release;
        logic              sda_release;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] rx_byte;
        logic              slave_nack;
    } res_t;

endpackage

`default_nettype wire

// ===== design/i2c_master_byte_engine.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master byte engine: start, stop, byte write and byte read on open-drain
// SCL and SDA, timed in quarter-bit phases of a programmable length.
//
// Each request on the input channel (func, tx_byte, sda_in) is one clock tick
// of the bus engine and yields exactly one result request on the output
// channel (line controls, busy, done, received byte, slave nack).
// A request is taken when in_valid is high and in_stall is low; a result is
// taken when out_valid is high and out_stall is low.
// A taken request passes through the input register and then the result
// register before its result is offered. Throughput: one request per
// cycle while the receiver does not stall. When the receiver stalls, the
// result holds and the input register keeps its request; in_stall rises
// only while both registers are full. Reset clears the valid flags of both
// registers, puts the sequencer idle with both lines released and loads a
// phase length of 150. phase_len is written over APB at byte address 0;
// the user must write it only while the block is idle, and the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [i2cm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [i2cm_pkg::DATA_W-1:0] pwdata,
    output logic      [i2cm_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [i2cm_pkg::FUNC_W-1:0] func,
    input  wire logic [i2cm_pkg::BYTE_W-1:0] tx_byte,
    input  wire logic                        sda_in,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             scl_release,
    output logic                             sda_release,
    output logic                             busy_res,
    output logic                             done_res,
    output logic      [i2cm_pkg::BYTE_W-1:0] rx_byte,
    output logic                             slave_nack
);
    import i2cm_pkg::*;

    logic [PLEN_W-1:0] phase_len;
    logic              in_valid_reg;
    logic [FUNC_W-1:0] func_reg;
    logic [BYTE_W-1:0] tx_reg;
    logic              sda_reg;
    logic              out_valid_reg;
    res_t              res_reg;
    res_t              res_next;
    logic              advance;
    logic              step;

    i2cm_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .phase_len (phase_len)
    );

    i2cm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .func      (func_reg),
        .tx_byte   (tx_reg),
        .sda_in    (sda_reg),
        .phase_len (phase_len),
        .res_next  (res_next)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            func_reg <= func;
            tx_reg   <= tx_byte;
            sda_reg  <= sda_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign scl_release = res_reg.scl_release;
    assign sda_release = res_reg.sda_release;
    assign busy_res    = res_reg.busy;
    assign done_res    = res_reg.done;
    assign rx_byte     = res_reg.rx_byte;
    assign slave_nack  = res_reg.slave_nack;

endmodule

`default_nettype wire

// ===== design/i2cm_apb_regs.sv =====
// ----------------------------------------------------------------------------
// i2cm_apb_regs
// APB configuration register holding the quarter-bit phase length.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_apb_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [i2cm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [i2cm_pkg::DATA_W-1:0] pwdata,
    output logic      [i2cm_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output logic      [i2cm_pkg::PLEN_W-1:0] phase_len
);
    import i2cm_pkg::*;

    logic [PLEN_W-1:0] phase_len_reg;
    logic              wr_en;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && (paddr[2] == REG_PHASE_LEN);
    assign phase_len = phase_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_len_reg <= PHASE_LEN_RESET;
        end
        else if (wr_en)
        begin
            phase_len_reg <= pwdata[PLEN_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_PHASE_LEN)
        begin
            prdata = {{(DATA_W-PLEN_W){1'b0}}, phase_len_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

endmodule

`default_nettype wire

// ===== design/i2cm_core.sv =====
// ----------------------------------------------------------------------------
// i2cm_core
// Command sequencer: phase timer, bit slots, shift register and line levels.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [i2cm_pkg::FUNC_W-1:0] func,
    input  wire logic [i2cm_pkg::BYTE_W-1:0] tx_byte,
    input  wire logic                        sda_in,
    input  wire logic [i2cm_pkg::PLEN_W-1:0] phase_len,
    output i2cm_pkg::res_t                   res_next
);
    import i2cm_pkg::*;

    cmd_t              st_reg,  st_next;
    logic [PLEN_W-1:0] cnt_reg, cnt_next;
    logic [1:0]        idx_reg, idx_next;
    logic [3:0]        bc_reg,  bc_next;
    logic [BYTE_W-1:0] sh_reg,  sh_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              ack_reg, ack_next;
    logic [BYTE_W-1:0] rx_reg,  rx_next;

    logic              done;
    logic              enter;
    logic              cmd_ok;
    logic              is_read;
    logic [PLEN_W:0]   cnt_inc;
    logic [PLEN_W-1:0] len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= CMD_IDLE;
            cnt_reg <= '0;
            idx_reg <= '0;
            bc_reg  <= '0;
            sh_reg  <= '0;
            scl_reg <= 1'b1;
            sda_reg <= 1'b1;
            ack_reg <= 1'b0;
            rx_reg  <= '0;
        end
        else if (step)
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            bc_reg  <= bc_next;
            sh_reg  <= sh_next;
            scl_reg <= scl_next;
            sda_reg <= sda_next;
            ack_reg <= ack_next;
            rx_reg  <= rx_next;
        end
    end

    assign cmd_ok  = (func >= CMD_START) && (func <= CMD_READ_NACK);
    assign cnt_inc = {1'b0, cnt_reg} + {{PLEN_W{1'b0}}, 1'b1};
    assign len     = (phase_len == '0) ? {{(PLEN_W-1){1'b0}}, 1'b1} : phase_len;

    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        bc_next  = bc_reg;
        sh_next  = sh_reg;
        scl_next = scl_reg;
        sda_next = sda_reg;
        ack_next = ack_reg;
        rx_next  = rx_reg;
        done     = 1'b0;
        enter    = 1'b0;

        if (st_reg == CMD_IDLE)
        begin
            if (cmd_ok)
            begin
                st_next  = cmd_t'(func);
                cnt_next = '0;
                idx_next = '0;
                bc_next  = '0;
                sh_next  = (func == CMD_WRITE) ? tx_byte : '0;
                enter    = 1'b1;
            end
        end
        else if (cnt_inc >= {1'b0, len})
        begin
            cnt_next = '0;
            if (idx_reg != LAST_PHASE)
            begin
                idx_next = idx_reg + 2'd1;
                enter    = 1'b1;
            end
            else
            begin
                idx_next = '0;
                if ((st_reg == CMD_START) || (st_reg == CMD_STOP) ||
                    (bc_reg >= LAST_BIT_SLOT))
                begin
                    if ((st_reg == CMD_WRITE) || (st_reg == CMD_READ_ACK) ||
                        (st_reg == CMD_READ_NACK))
                    begin
                        scl_next = 1'b0;
                    end
                    if ((st_reg == CMD_READ_ACK) || (st_reg == CMD_READ_NACK))
                    begin
                        rx_next = sh_reg;
                    end
                    st_next = CMD_IDLE;
                    bc_next = '0;
                    done    = 1'b1;
                end
                else
                begin
                    bc_next = bc_reg + 4'd1;
                    enter   = 1'b1;
                end
            end
        end
        else
        begin
            cnt_next = cnt_inc[PLEN_W-1:0];
        end

        is_read = (st_next == CMD_READ_ACK) || (st_next == CMD_READ_NACK);

        // line action at the first tick of the new phase
        if (enter)
        begin
            case (st_next)
                CMD_START:
                begin
                    case (idx_next)
                        2'd0:    sda_next = 1'b1;
                        2'd1:    scl_next = 1'b1;
                        2'd2:    sda_next = 1'b0;
                        default: scl_next = 1'b0;
                    endcase
                end
                CMD_STOP:
                begin
                    case (idx_next)
                        2'd0:    sda_next = 1'b0;
                        2'd1:    scl_next = 1'b1;
                        2'd2:    sda_next = 1'b1;
                        default: ;
                    endcase
                end
                CMD_WRITE, CMD_READ_ACK, CMD_READ_NACK:
                begin
                    case (idx_next)
                        2'd0:    scl_next = 1'b0;
                        2'd1:
                        begin
                            if (bc_next < LAST_BIT_SLOT)
                            begin
                                if (st_next == CMD_WRITE)
                                begin
                                    sda_next = sh_next[BYTE_W-1];
                                    sh_next  = {sh_next[BYTE_W-2:0], 1'b0};
                                end
                                else
                                begin
                                    sda_next = 1'b1;
                                end
                            end
                            else
                            begin
                                sda_next = (st_next == CMD_READ_ACK) ? 1'b0 : 1'b1;
                            end
                        end
                        2'd2:    scl_next = 1'b1;
                        default:
                        begin
                            if (bc_next < LAST_BIT_SLOT)
                            begin
                                if (is_read)
                                begin
                                    sh_next = {sh_next[BYTE_W-2:0], sda_in};
                                end
                            end
                            else if (st_next == CMD_WRITE)
                            begin
                                ack_next = sda_in;
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign res_next.scl_release = scl_next;
    assign res_next.sda_release = sda_next;
    assign res_next.busy        = (st_next != CMD_IDLE);
    assign res_next.done        = done;
    assign res_next.rx_byte     = rx_next;
    assign res_next.slave_nack  = ack_next;

endmodule

`default_nettype wire

// ===== design/i2cm_checker.sv =====
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the i2c master byte engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       scl_release,
    input wire logic       sda_release,
    input wire logic       busy_res,
    input wire logic       done_res,
    input wire logic [7:0] rx_byte,
    input wire logic       slave_nack
);

    // input back-pressure only comes from a stalled, full result stage
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a stalled result");

    // a taken request shows up as a valid result after the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> ##2 out_valid)
        else $error("result missing after accepted request");

    // a completing command leaves the engine idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> !busy_res)
        else $error("done with busy still set");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(scl_release) &&
        $stable(sda_release) && $stable(busy_res) && $stable(done_res) &&
        $stable(rx_byte) && $stable(slave_nack)))
        else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine i2cm_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .scl_release (scl_release),
    .sda_release (sda_release),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .rx_byte     (rx_byte),
    .slave_nack  (slave_nack)
);

`default_nettype wire
